// ----- src/ycc_pkg.sv -----
// shared types and constants for the ycbcr to rgb converter
package ycc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FULL_RANGE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_CODE = 1'd1;

   localparam logic [7:0] MATRIX_BT709      = 8'd1;
   localparam logic [7:0] MATRIX_BT2020     = 8'd9;
   localparam logic [7:0] MATRIX_CODE_RESET = 8'd2;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } ycc_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } ycc_rsp_type;

   // conversion coefficients scaled by 256; off is the unscaled luma offset
   typedef struct packed {
      logic [8:0] cy;
      logic [4:0] off;
      logic [9:0] crv;
      logic [6:0] cgu;
      logic [7:0] cgv;
      logic [9:0] cbu;
   } ycc_coef_type;

endpackage

// ----- src/ycc_csr.sv -----
// configuration registers and coefficient selection
module ycc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ycc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ycc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output ycc_pkg::ycc_coef_type               coef
);
   import ycc_pkg::*;

   logic       full_range_ff;
   logic       full_range_in;
   logic [7:0] matrix_code_ff;
   logic [7:0] matrix_code_in;

   always_comb begin
      full_range_in  = full_range_ff;
      matrix_code_in = matrix_code_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FULL_RANGE:  full_range_in  = csr_write_data[0];
            CSR_MATRIX_CODE: matrix_code_in = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_range_ff  <= 1'b0;
         matrix_code_ff <= MATRIX_CODE_RESET;
      end else begin
         full_range_ff  <= full_range_in;
         matrix_code_ff <= matrix_code_in;
      end
   end

   always_comb begin
      coef.cy  = full_range_ff ? 9'd256 : 9'd298;
      coef.off = full_range_ff ? 5'd0 : 5'd16;
      case (matrix_code_ff)
         MATRIX_BT709: begin
            coef.crv = full_range_ff ? 10'd403 : 10'd459;
            coef.cgu = full_range_ff ? 7'd48   : 7'd55;
            coef.cgv = full_range_ff ? 8'd120  : 8'd136;
            coef.cbu = full_range_ff ? 10'd475 : 10'd541;
         end
         MATRIX_BT2020: begin
            coef.crv = full_range_ff ? 10'd377 : 10'd430;
            coef.cgu = full_range_ff ? 7'd42   : 7'd48;
            coef.cgv = full_range_ff ? 8'd146  : 8'd167;
            coef.cbu = full_range_ff ? 10'd482 : 10'd548;
         end
         default: begin
            // bt.601 covers every other code
            coef.crv = full_range_ff ? 10'd359 : 10'd409;
            coef.cgu = full_range_ff ? 7'd88   : 7'd100;
            coef.cgv = full_range_ff ? 8'd183  : 8'd208;
            coef.cbu = full_range_ff ? 10'd454 : 10'd516;
         end
      endcase
   end

endmodule

// ----- src/ycc_datapath.sv -----
// input register, matrix multiply with rounding and clamp, result register
module ycc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ycc_pkg::ycc_coef_type coef,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ycc_pkg::ycc_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ycc_pkg::ycc_rsp_type  rsp_data
);
   import ycc_pkg::*;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   ycc_req_type s1_data_ff;
   logic        s2_valid_ff;
   logic        s2_valid_in;
   ycc_rsp_type s2_data_ff;
   ycc_rsp_type s2_data_in;
   logic        s2_open;
   logic        s1_move;

   logic signed [19:0] y_term;
   logic signed [19:0] cb_term;
   logic signed [19:0] cr_term;
   logic signed [19:0] lum;
   logic signed [19:0] red_sum;
   logic signed [19:0] green_sum;
   logic signed [19:0] blue_sum;

   // add the rounding half, shift by 8, clamp to 0..255
   function automatic logic [7:0] clamp_channel(input logic signed [19:0] sum);
      logic signed [19:0] t;
      t = sum + 20'sd128;
      if (t[19]) begin
         return 8'd0;
      end else if (t[18:16] != 3'd0) begin
         return 8'd255;
      end else begin
         return t[15:8];
      end
   endfunction

   assign s2_open   = !s2_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_open;
   assign req_ready = !s1_valid_ff || s2_open;

   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      y_term  = $signed({12'd0, s1_data_ff.luma}) - $signed({15'd0, coef.off});
      cb_term = $signed({12'd0, s1_data_ff.chroma_blue}) - 20'sd128;
      cr_term = $signed({12'd0, s1_data_ff.chroma_red}) - 20'sd128;
      lum       = $signed({11'd0, coef.cy}) * y_term;
      red_sum   = lum + $signed({10'd0, coef.crv}) * cr_term;
      green_sum = lum - $signed({13'd0, coef.cgu}) * cb_term
                      - $signed({12'd0, coef.cgv}) * cr_term;
      blue_sum  = lum + $signed({10'd0, coef.cbu}) * cb_term;
      s2_data_in.red   = clamp_channel(red_sum);
      s2_data_in.green = clamp_channel(green_sum);
      s2_data_in.blue  = clamp_channel(blue_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline not empty after reset");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_open |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("input stage lost or changed a stalled pixel");

   a_transfer_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted pixel did not reach the input stage");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> s2_valid_ff)
      else $error("moved pixel did not reach the result stage");
`endif

endmodule

// ----- src/ycbcr_to_rgb_converter.sv -----
// ycbcr to rgb pixel converter top level
//
//   channel  direction  handshake                payload
//   req_     in         req_valid / req_ready    luma, chroma_blue, chroma_red
//   rsp_     out        rsp_valid / rsp_ready    red, green, blue
//   csr_     in         csr_write_enable         csr_index, csr_write_data
//
// one pixel per cycle sustained while rsp_ready stays high; each pixel passes
// from its transfer in to its result through the input register and then the
// result register around the single multiply, round and clamp pass.
// synchronous reset empties both stages and restores full_range 0, matrix code 2.
// a stall on rsp_ready holds the result, and input is still taken while the
// input stage is empty.
module ycbcr_to_rgb_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ycc_pkg::ycc_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ycc_pkg::ycc_rsp_type                rsp_data,
   input  logic                                csr_write_enable,
   input  logic [ycc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ycc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import ycc_pkg::*;

   ycc_coef_type coef;

   ycc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .coef             (coef)
   );

   ycc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sim/ycbcr_to_rgb_converter_tb.sv -----
// self-checking testbench for the ycbcr to rgb pixel converter
`timescale 1ns / 100ps

module ycbcr_to_rgb_converter_tb;
   import ycc_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_PHASES   = 8;
   localparam int PIXELS_PER_PHASE = 100;
   localparam int REPORT_LIMIT    = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ycc_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ycc_rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   // shadow copy of the converter setup
   logic full_range_cfg = 1'b0;
   logic [7:0] matrix_code_cfg = MATRIX_CODE_RESET;

   idle_mode_type idle_mode = IDLE_NONE;
   ycc_req_type pixel_queue[$];
   ycc_rsp_type expected_rgb_q[$];
   int pixels_queued = 0;
   int pixels_accepted = 0;
   int error_count = 0;
   int stall_cycles = 0;

   ycbcr_to_rgb_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] clamp_channel(input int sum);
      int rounded;
      rounded = sum + 128;
      if (rounded < 0) begin
         return 8'd0;
      end
      rounded = rounded >>> 8;
      return (rounded > 255) ? 8'd255 : rounded[7:0];
   endfunction

   function automatic ycc_rsp_type predict_rgb(input ycc_req_type px);
      int cy, off, crv, cgu, cgv, cbu, cb, cr, luma_term;
      ycc_rsp_type rgb;
      cy = full_range_cfg ? 256 : 298;
      off = full_range_cfg ? 0 : 16;
      if (matrix_code_cfg == MATRIX_BT709) begin
         crv = full_range_cfg ? 403 : 459;
         cgu = full_range_cfg ? 48 : 55;
         cgv = full_range_cfg ? 120 : 136;
         cbu = full_range_cfg ? 475 : 541;
      end else if (matrix_code_cfg == MATRIX_BT2020) begin
         crv = full_range_cfg ? 377 : 430;
         cgu = full_range_cfg ? 42 : 48;
         cgv = full_range_cfg ? 146 : 167;
         cbu = full_range_cfg ? 482 : 548;
      end else begin
         crv = full_range_cfg ? 359 : 409;
         cgu = full_range_cfg ? 88 : 100;
         cgv = full_range_cfg ? 183 : 208;
         cbu = full_range_cfg ? 454 : 516;
      end
      cb = int'(px.chroma_blue) - 128;
      cr = int'(px.chroma_red) - 128;
      luma_term = cy * (int'(px.luma) - off);
      rgb.red = clamp_channel(luma_term + crv * cr);
      rgb.green = clamp_channel(luma_term - cgu * cb - cgv * cr);
      rgb.blue = clamp_channel(luma_term + cbu * cb);
      return rgb;
   endfunction

   function automatic bit roll_percent(input int percent);
      return $urandom_range(99) < percent;
   endfunction

   // biased toward range edges and the studio range limits
   function automatic logic [7:0] random_sample();
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd15;
            default: return 8'd128;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic queue_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
      ycc_req_type px;
      px.luma = y;
      px.chroma_blue = cb;
      px.chroma_red = cr;
      pixel_queue.push_back(px);
      pixels_queued++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FULL_RANGE) begin
         full_range_cfg = value[0];
      end else begin
         matrix_code_cfg = value;
      end
   endtask

   task automatic wait_drained();
      while (pixels_accepted != pixels_queued || expected_rgb_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // sender: next pixel goes out when the previous transfer is done
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_queue.size() != 0 &&
             !roll_percent(idle_mode == IDLE_SENDER ? 56 : idle_mode == IDLE_BOTH ? 12 : 0)) begin
            req_valid <= 1'b1;
            req_data <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !roll_percent(idle_mode == IDLE_RECEIVER ? 56 :
                                    idle_mode == IDLE_BOTH ? 12 : 0);
      end
   end

   // monitor: check results, then predict newly accepted pixels
   always @(posedge clock) begin
      ycc_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb_q.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("unexpected result transfer: r %0d g %0d b %0d",
                           rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end else begin
               want = expected_rgb_q.pop_front();
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("rgb mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                              want.red, want.green, want.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rgb_q.push_back(predict_rgb(req_data));
            pixels_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("ycbcr_to_rgb_converter test failed");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] range_value [RANDOM_PHASES];
      logic [7:0] code_value [RANDOM_PHASES];
      range_value = '{8'hff, 8'h00, 8'h01, 8'hfe, 8'h00, 8'h01, 8'h00, 8'h00};
      code_value = '{MATRIX_BT709, MATRIX_BT2020, 8'd0, 8'd255, MATRIX_BT709,
                     MATRIX_BT2020, 8'd0, 8'd2};
      range_value[6] = 8'($urandom_range(255));
      code_value[6] = 8'($urandom_range(255));
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corners at reset setup: limited range, default matrix
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd128, 8'd128);
      queue_pixel(8'd15, 8'd128, 8'd128);
      queue_pixel(8'd16, 8'd128, 8'd128);
      queue_pixel(8'd235, 8'd128, 8'd128);
      queue_pixel(8'd255, 8'd128, 8'd128);
      queue_pixel(8'd128, 8'd0, 8'd255);
      queue_pixel(8'd128, 8'd255, 8'd0);
      queue_pixel(8'd128, 8'd0, 8'd0);
      queue_pixel(8'd128, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd255, 8'd0);
      queue_pixel(8'd255, 8'd0, 8'd255);
      queue_pixel(8'd235, 8'd16, 8'd240);
      queue_pixel(8'd16, 8'd240, 8'd16);
      queue_pixel(8'haa, 8'h55, 8'haa);
      queue_pixel(8'h55, 8'haa, 8'h55);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_csr(CSR_FULL_RANGE, range_value[phase]);
         write_csr(CSR_MATRIX_CODE, code_value[phase]);
         idle_mode = idle_mode_type'(phase % 4);
         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            queue_pixel(random_sample(), random_sample(), random_sample());
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rgb_q.size() == 0) begin
         $display("ycbcr_to_rgb_converter test passed");
      end else begin
         $display("ycbcr_to_rgb_converter test failed");
      end
      $finish;
   end

endmodule
